// ===== hdl/sipd_pkg.sv =====
// Shared types, constants and the gamma table for the shake intensity peak detector.
package sipd_pkg;

    // Sample and fixed-point widths
    localparam int SAMPLE_BITS = 16;
    localparam int GAMMA_MILLI = 600;
    localparam int SUM_W       = 50;   // sum of three squared 25-bit differences
    localparam int ROOT_W      = 25;   // integer root of the sum
    localparam int ENERGY_W    = 17;
    localparam int ENV_W       = 33;   // Q17.16 envelope
    localparam int MUL_A_W     = 34;
    localparam int MUL_B_W     = 25;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_GRAVITY_ALPHA    = 3'd0;
    localparam logic [2:0] REG_ENVELOPE_RELEASE = 3'd1;
    localparam logic [2:0] REG_ENERGY_FLOOR     = 3'd2;
    localparam logic [2:0] REG_NORMALIZE_GAIN   = 3'd3;
    localparam logic [2:0] REG_PEAK_THRESHOLD   = 3'd4;
    localparam logic [2:0] REG_REFRACTORY_MS    = 3'd5;

    // Configuration register set
    typedef struct packed {
        logic [15:0] gravity_alpha;
        logic [15:0] envelope_release;
        logic [16:0] energy_floor;
        logic [23:0] normalize_gain;
        logic [16:0] peak_threshold;
        logic [15:0] refractory_ms;
    } t_cfg;

    typedef logic [7:0] t_gamma_lut [0:255];

    // Sign extend the used sample bits and scale to 16 fraction bits
    function automatic logic signed [31:0] sample_q16(input logic [15:0] raw);
        logic signed [SAMPLE_BITS-1:0] m;
        m = raw[SAMPLE_BITS-1:0];
        return 32'(m) <<< 16;
    endfunction

    // Integer square root, elaboration use only
    function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_v;
        v     = v_in;
        res   = 64'd0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (bit_v != 64'd0) begin
                if (v >= res + bit_v) begin
                    v   = v - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // log2 of 1..255 with 16 fraction bits, elaboration use only
    function automatic logic [31:0] log2_q16(input logic [7:0] v);
        logic [3:0]  msb;
        logic [15:0] frac;
        logic [63:0] x;
        msb  = 4'd0;
        frac = 16'd0;
        for (int b = 0; b < 8; b++) begin
            if (v[b]) msb = 4'(b);
        end
        x = 64'(v) << (30 - msb);
        for (int k = 0; k < 16; k++) begin
            x    = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                x       = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return {12'd0, msb, frac};
    endfunction

    // Gamma table: round(255 * (i/255)^(GAMMA_MILLI/1000)) in integer log/exp
    function automatic t_gamma_lut gamma_build();
        t_gamma_lut  lut;
        logic [63:0] roots [0:15];
        logic [31:0] lfull;
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] ip;
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] y;
        lfull    = log2_q16(8'd255);
        roots[0] = isqrt_c(64'd1 << 59);
        for (int j = 1; j < 16; j++) begin
            roots[j] = isqrt_c(roots[j-1] << 30);
        end
        lut[0] = 8'd0;
        for (int i = 1; i < 256; i++) begin
            n  = 64'(lfull - log2_q16(8'(i)));
            m  = (n * 64'(GAMMA_MILLI)) / 64'd1000;
            ip = m >> 16;
            f  = m & 64'hFFFF;
            r  = 64'd1 << 30;
            for (int j = 0; j < 16; j++) begin
                if (f[15-j]) r = (r * roots[j]) >> 30;
            end
            r = (ip >= 64'd31) ? 64'd0 : (r >> ip);
            y = (64'd255 * r + (64'd1 << 29)) >> 30;
            lut[i] = (y > 64'd255) ? 8'd255 : y[7:0];
        end
        return lut;
    endfunction

    localparam t_gamma_lut GAMMA_LUT = gamma_build();

    localparam logic [SUM_W-1:0] ISQRT_TOP = SUM_W'(1) << (SUM_W - 2);

endpackage

// ===== hdl/shake_intensity_peak_detector_core.sv =====
// Top level of the shake intensity peak detector: sequencer, state and stream ports.
//
// Each accepted sample (x, y, z, millisecond time) yields one result. The first
// sample after reset seeds the gravity estimate and gives an all-zero result. Every
// later sample runs the gravity update and the square for each axis in turn, then
// the square root, the envelope attack or decay, the gain and the gamma table. One
// shared 34x25 multiplier is used up to eight times in turn (three gravity updates,
// three squares, the envelope decay and the gain), and the dynamic magnitude comes
// from a square root unit that resolves one bit per cycle. The block is ready again
// as soon as the result moves into the output register. The block takes no new
// sample while one is in work, but a finished result sits in an output register, so
// the next sample can be taken while that result waits. Configuration is to be
// written through the APB port only while no sample is in work; the block itself
// does not enforce this.
module shake_intensity_peak_detector_core
    import sipd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // x [15:0], y [31:16], z [47:32], time_ms [79:48]
    input  logic [79:0]       s_axis_tdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // intensity [7:0], peak_magnitude [24:8], zero fill [31:25]
    output logic [31:0]       m_axis_tdata,
    // peak [0]
    output logic              m_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_G_MUL,
        S_G_UPD,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_ENV,
        S_ENV_MUL,
        S_ENV_UPD,
        S_LIN_MUL,
        S_LIN_UPD,
        S_FIN
    } t_state;

    t_state                    r_state;
    t_cfg                      w_cfg;
    logic signed [31:0]        r_s [3];
    logic signed [31:0]        r_g [3];
    logic [31:0]               r_t;
    logic [1:0]                r_axis;
    logic [SUM_W-1:0]          r_sum;
    logic [ENERGY_W-1:0]       r_energy;
    logic [ENV_W-1:0]          r_env;
    logic [ENERGY_W-1:0]       r_prev;
    logic [31:0]               r_last;
    logic                      r_seeded;
    logic [7:0]                r_res_int;
    logic                      r_res_peak;
    logic [ENERGY_W-1:0]       r_res_mag;
    logic                      r_out_valid;
    logic [7:0]                r_out_int;
    logic                      r_out_peak;
    logic [ENERGY_W-1:0]       r_out_mag;

    logic signed [32:0]        w_diff;
    logic signed [24:0]        w_d;
    logic [ENV_W-1:0]          w_floor;
    logic [ENV_W-1:0]          w_lin;
    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [MUL_P_W-1:0] w_p;
    logic                      w_sqrt_start;
    logic                      w_sqrt_done;
    logic [ROOT_W-1:0]         w_root;
    logic [7:0]                w_level;
    logic                      w_peak;
    logic                      w_in_xfer;
    logic                      w_out_free;

    sipd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sipd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    sipd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (r_sum),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // Handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_mag, r_out_int};
    assign m_axis_tuser  = r_out_peak;
    assign w_sqrt_start  = (r_state == S_SQRT_GO);

    // Per-axis difference to gravity, floored to 8 fraction bits for the square
    assign w_diff = {r_s[r_axis][31], r_s[r_axis]} - {r_g[r_axis][31], r_g[r_axis]};
    assign w_d    = w_diff[32:8];

    // Envelope above the dead zone
    assign w_floor = {w_cfg.energy_floor, 16'd0};
    assign w_lin   = (r_env > w_floor) ? (r_env - w_floor) : '0;

    // Gain result clamped to the table range
    assign w_level = (|w_p[56:40]) ? 8'hFF : w_p[39:32];

    // Rising crossing of the threshold outside the refractory time
    assign w_peak = (r_energy > w_cfg.peak_threshold) && (r_prev <= w_cfg.peak_threshold)
                 && ((r_t - r_last) > {16'd0, w_cfg.refractory_ms});

    // Select the multiplier operands for the current step
    always_comb begin
        unique case (r_state)
            S_G_MUL: begin
                w_a = {w_diff[32], w_diff};
                w_b = {9'd0, w_cfg.gravity_alpha};
            end
            S_SQ_MUL: begin
                w_a = {{9{w_d[24]}}, w_d};
                w_b = w_d;
            end
            S_ENV_MUL: begin
                w_a = {1'b0, r_env};
                w_b = {9'd0, w_cfg.envelope_release};
            end
            S_LIN_MUL: begin
                w_a = {1'b0, w_lin};
                w_b = {1'b0, w_cfg.normalize_gain};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_env       <= '0;
            r_prev      <= '0;
            r_last      <= '0;
            r_axis      <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                r_g[i] <= '0;
            end
        end else begin
            // drop the result once taken, unless a new one moves in
            if (r_out_valid && m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_s[0] <= sample_q16(s_axis_tdata[15:0]);
                        r_s[1] <= sample_q16(s_axis_tdata[31:16]);
                        r_s[2] <= sample_q16(s_axis_tdata[47:32]);
                        r_t    <= s_axis_tdata[79:48];
                        r_sum  <= '0;
                        r_axis <= 2'd0;
                        if (!r_seeded) begin
                            // seed gravity with this sample, result all zero
                            r_g[0]     <= sample_q16(s_axis_tdata[15:0]);
                            r_g[1]     <= sample_q16(s_axis_tdata[31:16]);
                            r_g[2]     <= sample_q16(s_axis_tdata[47:32]);
                            r_seeded   <= 1'b1;
                            r_res_int  <= 8'd0;
                            r_res_peak <= 1'b0;
                            r_res_mag  <= '0;
                            r_state    <= S_FIN;
                        end else begin
                            r_state <= S_G_MUL;
                        end
                    end
                end
                S_G_MUL: begin
                    r_state <= S_G_UPD;
                end
                S_G_UPD: begin
                    // g += floor(alpha * diff / 2^16)
                    r_g[r_axis] <= r_g[r_axis] + w_p[47:16];
                    r_state     <= S_SQ_MUL;
                end
                S_SQ_MUL: begin
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_sum <= r_sum + w_p[SUM_W-1:0];
                    if (r_axis == 2'd2) begin
                        r_state <= S_SQRT_GO;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_G_MUL;
                    end
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: begin
                    if (w_sqrt_done) begin
                        r_energy <= w_root[ROOT_W-1:8];
                        r_state  <= S_ENV;
                    end
                end
                S_ENV: begin
                    // fast attack, else decay
                    if ({r_energy, 16'd0} > r_env) begin
                        r_env   <= {r_energy, 16'd0};
                        r_state <= S_LIN_MUL;
                    end else begin
                        r_state <= S_ENV_MUL;
                    end
                end
                S_ENV_MUL: begin
                    r_state <= S_ENV_UPD;
                end
                S_ENV_UPD: begin
                    r_env   <= w_p[48:16];
                    r_state <= S_LIN_MUL;
                end
                S_LIN_MUL: begin
                    r_state <= S_LIN_UPD;
                end
                S_LIN_UPD: begin
                    r_res_int  <= GAMMA_LUT[w_level];
                    r_res_peak <= w_peak;
                    r_res_mag  <= w_peak ? r_energy : '0;
                    if (w_peak) begin
                        r_last <= r_t;
                    end
                    r_prev  <= r_energy;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hand the result over once the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_int   <= r_res_int;
                        r_out_peak  <= r_res_peak;
                        r_out_mag   <= r_res_mag;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/sipd_regs.sv =====
// APB configuration registers of the shake intensity peak detector.
module sipd_regs
    import sipd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_alpha    <= 16'd655;
            r_cfg.envelope_release <= 16'd62259;
            r_cfg.energy_floor     <= 17'd1024;
            r_cfg.normalize_gain   <= 24'd65535;
            r_cfg.peak_threshold   <= 17'd8192;
            r_cfg.refractory_ms    <= 16'd200;
        end else if (w_write) begin
            unique case (w_index)
                REG_GRAVITY_ALPHA:    r_cfg.gravity_alpha    <= pwdata[15:0];
                REG_ENVELOPE_RELEASE: r_cfg.envelope_release <= pwdata[15:0];
                REG_ENERGY_FLOOR:     r_cfg.energy_floor     <= pwdata[16:0];
                REG_NORMALIZE_GAIN:   r_cfg.normalize_gain   <= pwdata[23:0];
                REG_PEAK_THRESHOLD:   r_cfg.peak_threshold   <= pwdata[16:0];
                REG_REFRACTORY_MS:    r_cfg.refractory_ms    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_index)
            REG_GRAVITY_ALPHA:    prdata = DATA_W'(r_cfg.gravity_alpha);
            REG_ENVELOPE_RELEASE: prdata = DATA_W'(r_cfg.envelope_release);
            REG_ENERGY_FLOOR:     prdata = DATA_W'(r_cfg.energy_floor);
            REG_NORMALIZE_GAIN:   prdata = DATA_W'(r_cfg.normalize_gain);
            REG_PEAK_THRESHOLD:   prdata = DATA_W'(r_cfg.peak_threshold);
            REG_REFRACTORY_MS:    prdata = DATA_W'(r_cfg.refractory_ms);
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== hdl/sipd_mul.sv =====
// Shared registered signed multiplier of the shake intensity peak detector.
module sipd_mul
    import sipd_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    // Register the product; it appears in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hdl/sipd_isqrt.sv =====
// Bit-pair iterative integer square root of the shake intensity peak detector.
module sipd_isqrt
    import sipd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_res;
    logic [SUM_W-1:0] r_bit;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W-1:0] w_trial;
    logic             w_fits;

    assign w_trial = r_res + r_bit;
    assign w_fits  = (r_rem >= w_trial);
    assign o_done  = r_done;
    assign o_root  = r_res[ROOT_W-1:0];

    // One root bit per cycle, top bit pair first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_radicand;
                r_res  <= '0;
                r_bit  <= ISQRT_TOP;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_fits) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== test/tb_shake_intensity_peak_detector_core.sv =====
// Testbench for the shake intensity peak detector core, checked against a local predictor.
module tb_shake_intensity_peak_detector_core;
    import sipd_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int TAIL_CYCLES     = 60;
    localparam int RANDOM_PHASES   = 17;

    // Indexes that map to no register
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam logic [63:0] ENERGY_MAX = 64'd131071;
    localparam logic [63:0] LEVEL_MAX  = 64'd255;

    typedef struct packed {
        logic [7:0]  intensity;
        logic        peak;
        logic [16:0] peak_magnitude;
    } t_shake_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    // x [15:0], y [31:16], z [47:32], time_ms [79:48]
    logic [79:0]       s_axis_tdata  = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // intensity [7:0], peak_magnitude [24:8], zero fill [31:25]
    logic [31:0]       m_axis_tdata;
    // peak [0]
    logic              m_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predictor copy of the register set
    logic [15:0] cfg_alpha      = 16'd655;
    logic [15:0] cfg_release    = 16'd62259;
    logic [16:0] cfg_floor      = 17'd1024;
    logic [23:0] cfg_gain       = 24'd65535;
    logic [16:0] cfg_threshold  = 17'd8192;
    logic [15:0] cfg_refractory = 16'd200;

    // Predictor copy of the detector state
    longint      gravity_q16 [3] = '{0, 0, 0};
    logic [63:0] envelope_q16    = '0;
    logic [16:0] prior_energy    = '0;
    logic [31:0] last_peak_stamp = '0;
    bit          seeded          = 1'b0;
    logic [7:0]  gamma_curve [256];

    t_shake_result results_due [$];

    bit          tx_gaps_on    = 1'b1;
    bit          rx_stalls_on  = 1'b1;
    int          hold_request  = 0;
    bit          hold_active   = 1'b0;
    int          errors        = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          peaks_seen    = 0;
    int          settings_done = 0;
    int          idle_cycles   = 0;
    int          rest_x        = 0;
    int          rest_y        = 0;
    int          rest_z        = 16384;
    logic [31:0] now_ms        = '0;

    always #CLK_HALF i_clk = ~i_clk;

    shake_intensity_peak_detector_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Floor square root, one result bit per pass from the top
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // log2 of 1..255 with 16 fraction bits by repeated squaring
    function automatic logic [31:0] log2_fix16(input int unsigned v);
        logic [15:0] top;
        logic [15:0] frac;
        logic [63:0] x;
        top = '0;
        while ((v >> (top + 1)) != 0) top++;
        x    = 64'(v) << (30 - top);
        frac = '0;
        repeat (16) begin
            x    = (x * x) >> 30;
            frac = {frac[14:0], 1'b0};
            if (x >= (64'd1 << 31)) begin
                x       = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return {top, frac};
    endfunction

    // Build the gamma curve with integer log and exp
    initial begin : gamma_setup
        logic [63:0] root_tab [16];
        logic [31:0] full_log;
        logic [63:0] n_log;
        logic [63:0] m_log;
        logic [63:0] ip;
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] y;
        full_log    = log2_fix16(255);
        root_tab[0] = int_sqrt(64'd1 << 59);
        for (int j = 1; j < 16; j++) root_tab[j] = int_sqrt(root_tab[j-1] << 30);
        gamma_curve[0] = 8'd0;
        for (int i = 1; i < 256; i++) begin
            n_log = 64'(full_log - log2_fix16(i));
            m_log = (n_log * 64'(GAMMA_MILLI)) / 64'd1000;
            ip    = m_log >> 16;
            f     = m_log & 64'hFFFF;
            r     = 64'd1 << 30;
            for (int j = 0; j < 16; j++) begin
                if (f[15-j]) r = (r * root_tab[j]) >> 30;
            end
            r = (ip >= 64'd31) ? 64'd0 : (r >> ip);
            y = (64'd255 * r + (64'd1 << 29)) >> 30;
            gamma_curve[i] = (y > LEVEL_MAX) ? 8'd255 : y[7:0];
        end
    end

    // Advance the detector state by one sample and return its result
    function automatic t_shake_result compute_shake_result(
        input logic [15:0] ax, ay, az, input logic [31:0] t_ms);
        t_shake_result res;
        logic [15:0]   raw_v [3];
        longint        s [3];
        longint        d;
        logic [63:0]   mag;
        logic [63:0]   sq_sum;
        logic [63:0]   energy;
        logic [63:0]   floor_q16;
        logic [63:0]   lin;
        logic [63:0]   level;
        logic [31:0]   elapsed;
        res      = '0;
        raw_v[0] = ax;
        raw_v[1] = ay;
        raw_v[2] = az;
        for (int i = 0; i < 3; i++) begin
            s[i] = $signed(raw_v[i]);
            s[i] = s[i] * 65536;
        end
        // First sample only seeds gravity
        if (!seeded) begin
            for (int i = 0; i < 3; i++) gravity_q16[i] = s[i];
            seeded = 1'b1;
            return res;
        end
        sq_sum = '0;
        for (int i = 0; i < 3; i++) begin
            gravity_q16[i] += ((s[i] - gravity_q16[i]) * longint'(cfg_alpha)) >>> 16;
            d   = (s[i] - gravity_q16[i]) >>> 8;
            mag = (d < 0) ? -d : d;
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            sq_sum += mag * mag;
        end
        energy = int_sqrt(sq_sum) >> 8;
        if (energy > ENERGY_MAX) energy = ENERGY_MAX;
        // Fast attack, slow release
        if ((energy << 16) > envelope_q16) envelope_q16 = energy << 16;
        else envelope_q16 = (envelope_q16 * cfg_release) >> 16;
        floor_q16 = 64'(cfg_floor) << 16;
        lin       = (envelope_q16 > floor_q16) ? envelope_q16 - floor_q16 : 64'd0;
        level     = (lin * 64'(cfg_gain)) >> 32;
        if (level > LEVEL_MAX) level = LEVEL_MAX;
        res.intensity = gamma_curve[level[7:0]];
        // Rising crossing outside the refractory window
        elapsed = t_ms - last_peak_stamp;
        if (energy > 64'(cfg_threshold) && prior_energy <= cfg_threshold &&
            elapsed > 32'(cfg_refractory)) begin
            res.peak           = 1'b1;
            res.peak_magnitude = energy[16:0];
            last_peak_stamp    = t_ms;
        end
        prior_energy = energy[16:0];
        return res;
    endfunction

    // Offer one sample, optionally after a gap, and hold it until the transfer
    task automatic send_sample(input logic [15:0] ax, ay, az, input logic [31:0] t_ms);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t_ms, az, ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
        results_due.push_back(compute_shake_result(ax, ay, az, t_ms));
        items_sent++;
    endtask

    // Drop valid and wait for every pending result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // Setup and access phase of one register write
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_GRAVITY_ALPHA:    cfg_alpha      = value[15:0];
            REG_ENVELOPE_RELEASE: cfg_release    = value[15:0];
            REG_ENERGY_FLOOR:     cfg_floor      = value[16:0];
            REG_NORMALIZE_GAIN:   cfg_gain       = value[23:0];
            REG_PEAK_THRESHOLD:   cfg_threshold  = value[16:0];
            REG_REFRACTORY_MS:    cfg_refractory = value[15:0];
            default: ;
        endcase
    endtask

    // Set bits above the register width when asked
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int width,
                                              input bit dirty);
        logic [31:0] junk;
        junk = $urandom() << width;
        return dirty ? (value | junk) : value;
    endfunction

    task automatic load_settings(input int unsigned alpha, rel_factor, floor_lvl, gain,
                                 input int unsigned threshold, refractory, input bit dirty);
        write_register(REG_GRAVITY_ALPHA,    with_junk(alpha, 16, dirty));
        write_register(REG_ENVELOPE_RELEASE, with_junk(rel_factor, 16, dirty));
        write_register(REG_ENERGY_FLOOR,     with_junk(floor_lvl, 17, dirty));
        write_register(REG_NORMALIZE_GAIN,   with_junk(gain, 24, dirty));
        write_register(REG_PEAK_THRESHOLD,   with_junk(threshold, 17, dirty));
        write_register(REG_REFRACTORY_MS,    with_junk(refractory, 16, dirty));
        // Writes to unmapped indexes must leave everything alone
        if (dirty) begin
            write_register(REG_SPARE_A, $urandom());
            write_register(REG_SPARE_B, $urandom());
        end
        settings_done++;
    endtask

    function automatic int unsigned pick_setting(input int unsigned top, lo, hi);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Clamp a spread around a center to the 16-bit sample range
    function automatic logic [15:0] near(input int center, input int spread);
        int v;
        v = center - spread + int'($urandom_range(0, 2 * spread));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Quiet stretches at rest followed by shake bursts, with some raw noise
    task automatic run_shake_sequences(input int n_items);
        int sent;
        int q_len;
        int b_len;
        int amp;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                now_ms = $urandom();
                send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), now_ms);
                sent++;
            end else begin
                q_len = $urandom_range(2, 10);
                b_len = $urandom_range(1, 6);
                amp   = $urandom_range(256, 32767);
                for (int k = 0; k < q_len + b_len; k++) begin
                    if (k < q_len) begin
                        now_ms += $urandom_range(1, 60);
                        send_sample(near(rest_x, 150), near(rest_y, 150), near(rest_z, 150),
                                    now_ms);
                    end else begin
                        now_ms += $urandom_range(1, 20);
                        send_sample(near(rest_x, amp), near(rest_y, amp), near(rest_z, amp),
                                    now_ms);
                    end
                    sent++;
                end
            end
        end
    endtask

    task automatic pick_rest_vector();
        rest_x = int'($urandom_range(0, 32767)) - 16384;
        rest_y = int'($urandom_range(0, 32767)) - 16384;
        rest_z = int'($urandom_range(0, 32767)) - 16384;
    endtask

    // Seeding, field extremes, refractory blocking and time wrap at reset settings
    task automatic test_seed_and_directed();
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'd0);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'd10);
        send_sample(16'h7FFF, 16'h8000, 16'h4000, 32'd20);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'd30);
        send_sample(16'h7FFF, 16'h8000, 16'h4000, 32'd250);
        send_sample(16'h7FFF, 16'h8000, 16'h4000, 32'd260);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'd270);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 32'd300);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'd500);
        send_sample(16'h8000, 16'h8000, 16'h8000, 32'd600);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd610);
        send_sample(16'h0000, 16'h0000, 16'h0000, 32'd620);
        send_sample(16'hFFFF, 16'h0001, 16'hFFFF, 32'd630);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'd640);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'd650);
        // Timestamps across the 32-bit wrap
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'hFFFF_FF00);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFF0);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'hFFFF_FFF8);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 32'h0000_0040);
        send_sample(16'h0000, 16'h0000, 16'h4000, 32'h0000_0100);
        send_sample(16'h7FFF, 16'h7FFF, 16'h8000, 32'h0000_0200);
        drain_results();
    endtask

    // Oversized values and unmapped indexes
    task automatic test_register_writes();
        load_settings(1200, 60000, 512, 20000, 4000, 100, 1'b1);
        now_ms = 32'h0000_1000;
        run_shake_sequences(40);
        drain_results();
    endtask

    task automatic test_setting_extremes();
        load_settings(0, 0, 0, 0, 0, 0, 1'b0);
        run_shake_sequences(40);
        drain_results();
        load_settings(65535, 65535, 131071, 16777215, 131071, 65535, 1'b0);
        run_shake_sequences(40);
        drain_results();
        load_settings(0, 65535, 0, 16777215, 0, 0, 1'b0);
        run_shake_sequences(40);
        drain_results();
        load_settings(65535, 0, 131071, 0, 131071, 65535, 1'b0);
        run_shake_sequences(40);
        drain_results();
    endtask

    task automatic test_random_shakes();
        repeat (RANDOM_PHASES) begin
            load_settings(pick_setting(65535, 100, 8000),
                          pick_setting(65535, 40000, 65535),
                          pick_setting(131071, 0, 8000),
                          pick_setting(16777215, 256, 70000),
                          pick_setting(131071, 500, 30000),
                          pick_setting(65535, 0, 400),
                          $urandom_range(0, 3) == 0);
            pick_rest_vector();
            run_shake_sequences(50);
            drain_results();
        end
    endtask

    // Long receiver hold-off while samples keep coming
    task automatic test_receiver_hold_off();
        tx_gaps_on   = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        wait (hold_active);
        run_shake_sequences(16);
        drain_results();
        tx_gaps_on = 1'b1;
    endtask

    // Back-to-back transfers at reset settings
    task automatic test_steady_stream();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        load_settings(655, 62259, 1024, 65535, 8192, 200, 1'b0);
        pick_rest_vector();
        run_shake_sequences(150);
        drain_results();
    endtask

    // Pace the result side: random stalls and one requested long hold-off
    initial begin : sink_pacing
        int n;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request > 0) begin
                n            = hold_request;
                hold_request = 0;
                hold_active  = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                hold_active  = 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_shake_result want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                $error("result with no pending sample: tdata=%h tuser=%b",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (m_axis_tdata[7:0] !== want.intensity) begin
                    $error("intensity: expected %0d, got %0d", want.intensity,
                           m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tuser !== want.peak) begin
                    $error("peak: expected %0d, got %0d", want.peak, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[24:8] !== want.peak_magnitude) begin
                    $error("peak_magnitude: expected %0d, got %0d", want.peak_magnitude,
                           m_axis_tdata[24:8]);
                    errors++;
                end
                if (want.peak) peaks_seen++;
            end
        end
    end

    // End the run when no transfer happens for too long
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_seed_and_directed();
        test_register_writes();
        test_setting_extremes();
        test_random_shakes();
        test_receiver_hold_off();
        test_steady_stream();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d samples under %0d register settings; %0d results, %0d peaks.",
                 items_sent, settings_done, results_seen, peaks_seen);
        $display("Included seeding, axis extremes, time wrap, refractory blocking, %s",
                 "unmapped writes, a long output hold-off and a gap-free stream.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
